// File: rtl/bse_pkg.sv
// Shared constants, codes and the command type of the bitmap sort engine.
package bse_pkg;

    localparam int DATA_BITS         = 16;  // width of the value and sorted_value fields
    localparam int VALUE_BITS_DEF    = 16;
    localparam int VALUE_BITS_MAX    = 24;
    localparam int WORD_BITS         = 64;
    localparam int BIT_IDX_BITS      = $clog2(WORD_BITS);
    localparam int WORD_IDX_MAX_BITS = VALUE_BITS_MAX - BIT_IDX_BITS;
    localparam int BYTE_BITS         = 8;
    localparam int WORD_BYTES        = WORD_BITS / BYTE_BITS;
    localparam int BYTE_SEL_BITS     = $clog2(WORD_BYTES);
    localparam int BYTE_BIT_BITS     = $clog2(BYTE_BITS);
    localparam int QUEUE_DEPTH       = 2;
    localparam int QUEUE_PTR_BITS    = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_POP    = 1'b1
    } kind_t;

    // One classified command as it sits in the queue between front and back.
    typedef struct packed {
        kind_t                          kind;
        logic [WORD_IDX_MAX_BITS-1:0]   word;
        logic [BIT_IDX_BITS-1:0]        bit_idx;
    } bse_cmd_t;

endpackage

// File: rtl/bse_front.sv
// Input side: takes beats, splits the value into word and bit index, queues commands.
module bse_front import bse_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [DATA_BITS-1:0] s_value,
    input  logic                 clearing,
    output logic                 cmd_valid,
    output bse_cmd_t             cmd,
    input  logic                 cmd_take
);

    bse_cmd_t                  queue_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;
    logic [31:0]               value_wide;
    logic [VALUE_BITS-1:0]     value_eff;
    bse_cmd_t                  new_cmd;
    logic                      push, pop;

    // values wider than the set wrap onto its low bits
    assign value_wide      = 32'(s_value);
    assign value_eff       = value_wide[VALUE_BITS-1:0];
    assign new_cmd.kind    = kind_t'(s_kind);
    assign new_cmd.word    = WORD_IDX_MAX_BITS'(value_eff[VALUE_BITS-1:BIT_IDX_BITS]);
    assign new_cmd.bit_idx = value_eff[BIT_IDX_BITS-1:0];

    assign s_ready   = (count_reg != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH)) && !clearing;
    assign push      = s_valid && s_ready;
    assign pop       = cmd_take;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// File: rtl/bse_back.sv
// Execution side: bitmap memory, clearing pass, insert read-modify-write and pop scan.
module bse_back import bse_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    input  bse_cmd_t             cmd,
    output logic                 cmd_take,
    output logic                 clearing,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_BITS-1:0] m_sorted_value,
    output logic                 m_found
);

    localparam int AW    = VALUE_BITS - BIT_IDX_BITS;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS_WR,
        ST_SCAN,
        ST_PICK
    } state_t;

    logic [WORD_BITS-1:0]     mem [DEPTH];
    logic [WORD_BITS-1:0]     rdata_reg;

    state_t                   state_reg;
    logic [AW-1:0]            clr_addr_reg;
    logic [AW-1:0]            ptr_reg;
    logic [AW-1:0]            addr_reg;
    logic [BIT_IDX_BITS-1:0]  bit_reg;
    logic [WORD_BITS-1:0]     word_reg;
    logic [BYTE_SEL_BITS-1:0] byte_sel_reg;
    logic [BYTE_BITS-1:0]     byte_reg;
    logic                     m_valid_reg;
    logic [DATA_BITS-1:0]     m_sorted_value_reg;
    logic                     m_found_reg;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [AW-1:0]            mem_raddr;
    logic [WORD_BITS-1:0]     mem_wdata;
    logic [BYTE_SEL_BITS-1:0] scan_sel;
    logic [BYTE_BITS-1:0]     scan_byte;
    logic [BYTE_BIT_BITS-1:0] pick_bit;
    logic [BIT_IDX_BITS-1:0]  pick_idx;
    logic [VALUE_BITS-1:0]    popped;

    assign clearing       = (state_reg == ST_CLEAR);
    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_sorted_value_reg;
    assign m_found        = m_found_reg;

    // a pop is only started with the result slot empty
    assign cmd_take = (state_reg == ST_IDLE) && cmd_valid &&
                      ((cmd.kind == KIND_INSERT) || !m_valid_reg);

    // first nonzero byte of the word just read
    always_comb begin
        scan_sel = '0;
        for (int i = WORD_BYTES - 1; i >= 0; i--) begin
            if (|rdata_reg[i*BYTE_BITS +: BYTE_BITS]) begin
                scan_sel = BYTE_SEL_BITS'(i);
            end
        end
        scan_byte = rdata_reg[scan_sel*BYTE_BITS +: BYTE_BITS];
    end

    // first set bit inside the chosen byte
    always_comb begin
        pick_bit = '0;
        for (int i = BYTE_BITS - 1; i >= 0; i--) begin
            if (byte_reg[i]) begin
                pick_bit = BYTE_BIT_BITS'(i);
            end
        end
    end

    assign pick_idx = {byte_sel_reg, pick_bit};
    assign popped   = {addr_reg, pick_idx};

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        mem_raddr = addr_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
            end
            ST_IDLE: begin
                mem_raddr = (cmd.kind == KIND_INSERT) ? cmd.word[AW-1:0] : ptr_reg;
            end
            ST_INS_WR: begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg | (WORD_BITS'(1) << bit_reg);
            end
            ST_SCAN: begin
                mem_raddr = addr_reg + 1'b1;
            end
            ST_PICK: begin
                mem_we    = 1'b1;
                mem_wdata = word_reg & ~(WORD_BITS'(1) << pick_idx);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            ptr_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == '1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (cmd_take) begin
                        addr_reg  <= mem_raddr;
                        bit_reg   <= cmd.bit_idx;
                        state_reg <= (cmd.kind == KIND_INSERT) ? ST_INS_WR : ST_SCAN;
                    end
                end
                ST_INS_WR: begin
                    if (addr_reg < ptr_reg) begin
                        ptr_reg <= addr_reg;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (rdata_reg != '0) begin
                        word_reg     <= rdata_reg;
                        byte_sel_reg <= scan_sel;
                        byte_reg     <= scan_byte;
                        state_reg    <= ST_PICK;
                    end else if (addr_reg == '1) begin
                        // set empty: report not found and restart scans at word zero
                        ptr_reg            <= '0;
                        m_valid_reg        <= 1'b1;
                        m_found_reg        <= 1'b0;
                        m_sorted_value_reg <= '0;
                        state_reg          <= ST_IDLE;
                    end else begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_PICK: begin
                    ptr_reg            <= addr_reg;
                    m_valid_reg        <= 1'b1;
                    m_found_reg        <= 1'b1;
                    m_sorted_value_reg <= DATA_BITS'(popped);
                    state_reg          <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/bitmap_sort_engine.sv
// Top level of the bitmap sort engine: command queue front and bitmap execution back.
//
// Use: s_* carries commands (s_kind 0 inserts s_value, 1 pops the smallest stored value),
// m_* carries one result beat per pop (m_found, m_sorted_value); inserts give no beat.
// Values are kept as one bit each in 2^(VALUE_BITS-6) words of 64 bits in a single memory,
// so duplicates collapse and pops come out in ascending order; popping clears the bit.
// Front: a two-entry queue takes a beat per cycle while it has room and no clearing pass runs.
// Back: one command at a time, one memory read and one write per cycle.
//   insert: read the word, then write it back with the bit set.
//   pop: scan words from the scan pointer up to the first nonzero one, then pick and clear
//        its lowest set bit; an empty set scans from the pointer to the top word.
//   The back takes a queued beat the cycle after acceptance at the earliest, then reads,
//   scans and picks before a found pop shows on m_valid.
// The scan pointer marks the lowest word that can hold a bit, so drains stay short.
// Reset (aresetn low, synchronous): queue empties, then a clearing pass writes zero to
// every word (1024 words by default), with s_ready low throughout.
// Receiver stall: the result sits in the output register; inserts go on behind it, but
// the next pop waits until the beat is taken; meanwhile the queue fills and s_ready drops.
module bitmap_sort_engine import bse_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [DATA_BITS-1:0] s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_BITS-1:0] m_sorted_value,
    output logic                 m_found
);

    logic     cmd_valid;
    logic     cmd_take;
    logic     clearing;
    bse_cmd_t cmd;

    bse_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_value   (s_value),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    bse_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_take       (cmd_take),
        .clearing       (clearing),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_found        (m_found)
    );

endmodule

// File: rtl/bse_checker.sv
// Port-level checks on the bitmap sort engine, bound to the top level.
module bse_checker import bse_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [DATA_BITS-1:0] m_sorted_value,
    input logic                 m_found
);

    // a stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sorted_value) && $stable(m_found))
        else $error("result beat changed while stalled");

    // an empty pop reports value zero
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_sorted_value == '0)
        else $error("not-found beat with nonzero value");

    // clearing pass follows reset: nothing accepted or shown
    a_reset_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready && !m_valid)
        else $error("activity straight after reset");

    // while still clearing no result can appear
    a_no_out_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready && !$past(s_ready) && $past(!aresetn, 2) |-> !m_valid)
        else $error("result during clearing pass");

endmodule

bind bitmap_sort_engine bse_checker u_bse_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_sorted_value (m_sorted_value),
    .m_found        (m_found)
);
